### src/psc_pkg.sv
// ----------------------------------------------------------------------------
// psc_pkg: shared constants and helpers
// Constants for single-precision special values, register indexes and the
// leading-zero counters used by the floating-point units.
// ----------------------------------------------------------------------------
package psc_pkg;

	// Single-precision encodings.
	localparam logic [31:0] QUIET_BIT   = 32'h0040_0000;
	localparam logic [31:0] DEFAULT_NAN = 32'hFFC0_0000;
	localparam logic [31:0] SQRT_NAN    = 32'h7FC0_0000;
	localparam logic [7:0]  EXP_ALL_ONE = 8'hFF;

	// Result bits produced by the square-root recurrence, one per stage.
	localparam int SQ_STEPS = 25;

	// Configuration register indexes.
	localparam int REG_TERM_COUNT = 0;
	localparam int REG_COEF_BASE  = 1;

	// Leading-zero count of a 48-bit product.
	function automatic logic [5:0] lzc48(input logic [47:0] v);
		logic [5:0] n;
		n = 6'd48;
		for (int i = 0; i < 48; i++) begin
			if (v[i]) n = 6'(47 - i);
		end
		return n;
	endfunction

	// Leading-zero count of a 28-bit sum.
	function automatic logic [4:0] lzc28(input logic [27:0] v);
		logic [4:0] n;
		n = 5'd28;
		for (int i = 0; i < 28; i++) begin
			if (v[i]) n = 5'(27 - i);
		end
		return n;
	endfunction

	// Leading-zero count of a 24-bit significand.
	function automatic logic [4:0] lzc24(input logic [23:0] v);
		logic [4:0] n;
		n = 5'd24;
		for (int i = 0; i < 24; i++) begin
			if (v[i]) n = 5'(23 - i);
		end
		return n;
	endfunction

endpackage

### src/psc_stream_if.sv
// ----------------------------------------------------------------------------
// psc_sample_if / psc_result_if: valid-ready channels
// One channel carries raw samples in, the other calibrated values out.
// ----------------------------------------------------------------------------
interface psc_sample_if;
	logic        valid;
	logic        ready;
	logic [31:0] sample_value;

	modport source (output valid, output sample_value, input ready);
	modport sink   (input valid, input sample_value, output ready);
endinterface

interface psc_result_if;
	logic        valid;
	logic        ready;
	logic [31:0] calibrated_value;

	modport source (output valid, output calibrated_value, input ready);
	modport sink   (input valid, input calibrated_value, output ready);
endinterface

### src/psc_fmul.sv
// ----------------------------------------------------------------------------
// psc_fmul: two-stage single-precision multiplier
// Stage one forms the significand product, stage two normalises and rounds
// to nearest even, including subnormal results. A tag travels alongside.
// ----------------------------------------------------------------------------
module psc_fmul import psc_pkg::*; #(
	parameter int TW = 32
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          en,
	input  logic          in_valid,
	input  logic [31:0]   a,
	input  logic [31:0]   b,
	input  logic [TW-1:0] in_tag,
	output logic          out_valid,
	output logic [31:0]   res,
	output logic [TW-1:0] out_tag
);

	logic        a_nan, b_nan, a_inf, b_inf, a_zero, b_zero, sgn;
	logic        spec;
	logic [31:0] spec_val;
	logic [23:0] ma, mb;
	logic [7:0]  ea, eb;

	logic               v_s1, s_s1, spec_s1;
	logic [31:0]        spec_val_s1;
	logic [47:0]        prod_s1;
	logic signed [10:0] e_s1;
	logic [TW-1:0]      tag_s1;

	logic               v_s2;
	logic [31:0]        res_s2;
	logic [TW-1:0]      tag_s2;

	logic [5:0]         lz;
	logic [47:0]        norm, m;
	logic signed [10:0] e2, shv;
	logic [5:0]         sh;
	logic [96:0]        wide;
	logic               sticky, up, ovf;
	logic [7:0]         ef;
	logic [30:0]        pk;
	logic [31:0]        res_c;

	// Operand classification and special results.
	always_comb begin
		a_nan  = (a[30:23] == EXP_ALL_ONE) && (a[22:0] != 23'd0);
		b_nan  = (b[30:23] == EXP_ALL_ONE) && (b[22:0] != 23'd0);
		a_inf  = (a[30:23] == EXP_ALL_ONE) && (a[22:0] == 23'd0);
		b_inf  = (b[30:23] == EXP_ALL_ONE) && (b[22:0] == 23'd0);
		a_zero = (a[30:0] == 31'd0);
		b_zero = (b[30:0] == 31'd0);
		sgn    = a[31] ^ b[31];
		spec     = 1'b1;
		spec_val = 32'd0;
		if (a_nan) begin
			spec_val = a | QUIET_BIT;
		end else if (b_nan) begin
			spec_val = b | QUIET_BIT;
		end else if ((a_inf && b_zero) || (a_zero && b_inf)) begin
			spec_val = DEFAULT_NAN;
		end else if (a_inf || b_inf) begin
			spec_val = {sgn, EXP_ALL_ONE, 23'd0};
		end else if (a_zero || b_zero) begin
			spec_val = {sgn, 31'd0};
		end else begin
			spec = 1'b0;
		end
		ma = {a[30:23] != 8'd0, a[22:0]};
		mb = {b[30:23] != 8'd0, b[22:0]};
		ea = (a[30:23] == 8'd0) ? 8'd1 : a[30:23];
		eb = (b[30:23] == 8'd0) ? 8'd1 : b[30:23];
	end

	// Stage one: significand product and raw exponent.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			prod_s1     <= ma * mb;
			e_s1        <= $signed({3'b0, ea}) + $signed({3'b0, eb}) - 11'sd127;
			s_s1        <= sgn;
			spec_s1     <= spec;
			spec_val_s1 <= spec_val;
			tag_s1      <= in_tag;
		end
	end

	// Normalise, denormalise where the exponent underflows, round to nearest even.
	always_comb begin
		lz   = lzc48(prod_s1);
		norm = prod_s1 << lz;
		e2   = e_s1 + 11'sd1 - $signed({5'b0, lz});
		shv  = 11'sd1 - e2;
		sh   = (shv > 11'sd49) ? 6'd49 : shv[5:0];
		wide = {norm, 49'd0} >> sh;
		if (e2 < 11'sd1) begin
			m      = wide[96:49];
			sticky = |wide[48:0];
			ef     = 8'd0;
		end else begin
			m      = norm;
			sticky = 1'b0;
			ef     = e2[7:0];
		end
		up    = m[23] & ((|m[22:0]) | sticky | m[24]);
		ovf   = (e2 > 11'sd254);
		pk    = {ef, m[46:24]} + 31'(up);
		if (spec_s1) begin
			res_c = spec_val_s1;
		end else if (ovf) begin
			res_c = {s_s1, EXP_ALL_ONE, 23'd0};
		end else begin
			res_c = {s_s1, pk};
		end
	end

	// Stage two: rounded result.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (en) begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			res_s2 <= res_c;
			tag_s2 <= tag_s1;
		end
	end

	assign out_valid = v_s2;
	assign res       = res_s2;
	assign out_tag   = tag_s2;

endmodule

### src/psc_fadd.sv
// ----------------------------------------------------------------------------
// psc_fadd: two-stage single-precision adder
// Stage one orders the operands by magnitude, aligns and adds; stage two
// normalises and rounds to nearest even. A tag travels alongside.
// ----------------------------------------------------------------------------
module psc_fadd import psc_pkg::*; #(
	parameter int TW = 32
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          en,
	input  logic          in_valid,
	input  logic [31:0]   a,
	input  logic [31:0]   b,
	input  logic [TW-1:0] in_tag,
	output logic          out_valid,
	output logic [31:0]   res,
	output logic [TW-1:0] out_tag
);

	logic        a_nan, b_nan, a_inf, b_inf, a_zero, b_zero;
	logic        spec, swap;
	logic [31:0] spec_val, opl, ops;
	logic [23:0] ml, ms;
	logic [7:0]  el, es, d;
	logic [4:0]  dc;
	logic [53:0] t;
	logic [26:0] ms_al;
	logic [27:0] sum;

	logic          v_s1, s_s1, spec_s1;
	logic [31:0]   spec_val_s1;
	logic [27:0]   sum_s1;
	logic [7:0]    el_s1;
	logic [TW-1:0] tag_s1;

	logic          v_s2;
	logic [31:0]   res_s2;
	logic [TW-1:0] tag_s2;

	logic [4:0]        lz;
	logic signed [9:0] e2;
	logic [27:0]       n;
	logic [7:0]        ef;
	logic              up, ovf;
	logic [30:0]       pk;
	logic [31:0]       res_c;

	// Classification, operand ordering and alignment.
	always_comb begin
		a_nan  = (a[30:23] == EXP_ALL_ONE) && (a[22:0] != 23'd0);
		b_nan  = (b[30:23] == EXP_ALL_ONE) && (b[22:0] != 23'd0);
		a_inf  = (a[30:23] == EXP_ALL_ONE) && (a[22:0] == 23'd0);
		b_inf  = (b[30:23] == EXP_ALL_ONE) && (b[22:0] == 23'd0);
		a_zero = (a[30:0] == 31'd0);
		b_zero = (b[30:0] == 31'd0);
		spec     = 1'b1;
		spec_val = 32'd0;
		if (a_nan) begin
			spec_val = a | QUIET_BIT;
		end else if (b_nan) begin
			spec_val = b | QUIET_BIT;
		end else if (a_inf && b_inf && (a[31] != b[31])) begin
			spec_val = DEFAULT_NAN;
		end else if (a_inf) begin
			spec_val = a;
		end else if (b_inf) begin
			spec_val = b;
		end else if (a_zero && b_zero) begin
			spec_val = {a[31] & b[31], 31'd0};
		end else begin
			spec = 1'b0;
		end
		swap  = (b[30:0] > a[30:0]);
		opl   = swap ? b : a;
		ops   = swap ? a : b;
		ml    = {opl[30:23] != 8'd0, opl[22:0]};
		ms    = {ops[30:23] != 8'd0, ops[22:0]};
		el    = (opl[30:23] == 8'd0) ? 8'd1 : opl[30:23];
		es    = (ops[30:23] == 8'd0) ? 8'd1 : ops[30:23];
		d     = el - es;
		dc    = (d > 8'd31) ? 5'd31 : d[4:0];
		t     = {ms, 3'd0, 27'd0} >> dc;
		ms_al = t[53:27] | {26'd0, |t[26:0]};
		if (opl[31] != ops[31]) begin
			sum = {1'b0, ml, 3'd0} - {1'b0, ms_al};
		end else begin
			sum = {1'b0, ml, 3'd0} + {1'b0, ms_al};
		end
	end

	// Stage one: raw sum.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			sum_s1      <= sum;
			el_s1       <= el;
			s_s1        <= opl[31];
			spec_s1     <= spec;
			spec_val_s1 <= spec_val;
			tag_s1      <= in_tag;
		end
	end

	// Normalisation and rounding; an exact cancellation gives +0.
	always_comb begin
		lz = lzc28(sum_s1);
		e2 = $signed({2'b0, el_s1}) + 10'sd1 - $signed({5'b0, lz});
		if (e2 >= 10'sd1) begin
			n  = sum_s1 << lz;
			ef = e2[7:0];
		end else begin
			n  = sum_s1 << el_s1[4:0];
			ef = 8'd0;
		end
		up  = n[3] & ((|n[2:0]) | n[4]);
		ovf = (e2 > 10'sd254);
		pk  = {ef, n[26:4]} + 31'(up);
		if (spec_s1) begin
			res_c = spec_val_s1;
		end else if (sum_s1 == 28'd0) begin
			res_c = 32'd0;
		end else if (ovf) begin
			res_c = {s_s1, EXP_ALL_ONE, 23'd0};
		end else begin
			res_c = {s_s1, pk};
		end
	end

	// Stage two: rounded result.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (en) begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			res_s2 <= res_c;
			tag_s2 <= tag_s1;
		end
	end

	assign out_valid = v_s2;
	assign res       = res_s2;
	assign out_tag   = tag_s2;

endmodule

### src/psc_fsqrt.sv
// ----------------------------------------------------------------------------
// psc_fsqrt: pipelined single-precision square root
// A normalising front stage, one restoring-recurrence stage per result bit
// and a rounding stage give a correctly rounded root. A tag travels alongside.
// ----------------------------------------------------------------------------
module psc_fsqrt import psc_pkg::*; #(
	parameter int TW = 32
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          en,
	input  logic          in_valid,
	input  logic [31:0]   a,
	input  logic [TW-1:0] in_tag,
	output logic          out_valid,
	output logic [31:0]   res,
	output logic [TW-1:0] out_tag
);

	// Recurrence registers; index k holds the state entering step k.
	logic [50:0]       rv_s    [0:SQ_STEPS];
	logic [50:0]       root_s  [0:SQ_STEPS];
	logic signed [8:0] he_s    [0:SQ_STEPS];
	logic              spec_s  [0:SQ_STEPS];
	logic [31:0]       sval_s  [0:SQ_STEPS];
	logic [TW-1:0]     tag_s   [0:SQ_STEPS];
	logic              v_s     [0:SQ_STEPS];

	logic              spec;
	logic [31:0]       sval;
	logic [7:0]        ea;
	logic [23:0]       m24, mn;
	logic [4:0]        lz;
	logic signed [9:0] e, e_adj;
	logic [24:0]       m2;

	logic              v_q;
	logic [31:0]       res_q;
	logic [TW-1:0]     tag_q;

	logic [23:0]       sig;
	logic              rnd;
	logic [24:0]       sig1;
	logic [22:0]       frac;
	logic signed [8:0] he_f;
	logic [7:0]        ex_f;
	logic [31:0]       res_c;

	// Front stage: specials, subnormal normalisation, even exponent.
	always_comb begin
		spec = 1'b1;
		sval = a;
		if (a[30:23] == EXP_ALL_ONE) begin
			if (a[22:0] != 23'd0) begin
				sval = a | QUIET_BIT;
			end else if (a[31]) begin
				sval = SQRT_NAN;
			end
		end else if (a[30:0] == 31'd0) begin
			sval = a;
		end else if (a[31]) begin
			sval = SQRT_NAN;
		end else begin
			spec = 1'b0;
		end
		ea    = (a[30:23] == 8'd0) ? 8'd1 : a[30:23];
		m24   = {a[30:23] != 8'd0, a[22:0]};
		lz    = lzc24(m24);
		mn    = m24 << lz;
		e     = $signed({2'b0, ea}) - 10'sd127 - $signed({5'b0, lz});
		m2    = e[0] ? {mn, 1'b0} : {1'b0, mn};
		e_adj = e - $signed({9'd0, e[0]});
		// e_adj is even, so the shift halves it exactly.
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s[0] <= 1'b0;
		end else if (en) begin
			v_s[0] <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rv_s[0]   <= {1'b0, m2, 25'd0};
			root_s[0] <= 51'd0;
			he_s[0]   <= 9'(e_adj >>> 1);
			spec_s[0] <= spec;
			sval_s[0] <= sval;
			tag_s[0]  <= in_tag;
		end
	end

	// One result bit per stage.
	for (genvar k = 0; k < SQ_STEPS; k++) begin : g_step
		localparam int SH = 2 * (SQ_STEPS - 1 - k);
		logic [50:0] bitv, trial;
		logic        ge;

		assign bitv  = 51'd1 << SH;
		assign trial = root_s[k] + bitv;
		assign ge    = (rv_s[k] >= trial);

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[k+1] <= 1'b0;
			end else if (en) begin
				v_s[k+1] <= v_s[k];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rv_s[k+1]   <= ge ? (rv_s[k] - trial) : rv_s[k];
				root_s[k+1] <= ge ? ((root_s[k] >> 1) + bitv) : (root_s[k] >> 1);
				he_s[k+1]   <= he_s[k];
				spec_s[k+1] <= spec_s[k];
				sval_s[k+1] <= sval_s[k];
				tag_s[k+1]  <= tag_s[k];
			end
		end
	end

	// Round to nearest even and pack.
	always_comb begin
		sig  = root_s[SQ_STEPS][24:1];
		rnd  = root_s[SQ_STEPS][0] & ((rv_s[SQ_STEPS] != 51'd0) | sig[0]);
		sig1 = {1'b0, sig} + 25'(rnd);
		if (sig1[24]) begin
			frac = sig1[23:1];
			he_f = he_s[SQ_STEPS] + 9'sd1;
		end else begin
			frac = sig1[22:0];
			he_f = he_s[SQ_STEPS];
		end
		ex_f  = 8'(he_f + 9'sd127);
		res_c = spec_s[SQ_STEPS] ? sval_s[SQ_STEPS] : {1'b0, ex_f, frac};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q <= 1'b0;
		end else if (en) begin
			v_q <= v_s[SQ_STEPS];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			res_q <= res_c;
			tag_q <= tag_s[SQ_STEPS];
		end
	end

	assign out_valid = v_q;
	assign res       = res_q;
	assign out_tag   = tag_q;

endmodule

### src/polynomial_sqrt_calibration_top.sv
// ----------------------------------------------------------------------------
// polynomial_sqrt_calibration_top: single-precision polynomial calibration
//
//   Channel   Dir   Payload                 Transfer
//   sample    in    sample_value[31:0]      valid & ready
//   result    out   calibrated_value[31:0]  valid & ready
//   cfg       in    cfg_idx, cfg_wdata      cfg_we
//
// One item is accepted per clock while the result channel is not stalled.
// An item passes the square-root pipeline, the root weighting, each Horner
// step (multiplier then adder), the final add and one output register.
// Reset clears all valid bits and the configuration registers.
// A stall on the result channel freezes every stage at once; nothing moves,
// so nothing is lost or repeated.
// ----------------------------------------------------------------------------
module polynomial_sqrt_calibration_top import psc_pkg::*; #(
	parameter int MAX_TERMS = 6
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_we,
	input  logic [$clog2(MAX_TERMS+1)-1:0]     cfg_idx,
	input  logic [31:0]                        cfg_wdata,
	psc_sample_if.sink                         sample,
	psc_result_if.source                       result
);

	localparam int IW = (MAX_TERMS > 1) ? $clog2(MAX_TERMS) : 1;
	localparam int NSTEP = MAX_TERMS - 1;

	logic signed [3:0] tc_q;
	logic [31:0]       coef_q [0:MAX_TERMS-1];

	logic        en;
	int          mag_i, deg_i, wi_i;
	logic        mode_pos, mode_neg;
	logic [IW-1:0] deg_idx, w_idx;

	// Configuration writes; unused indexes fall through.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tc_q <= 4'sd0;
			for (int i = 0; i < MAX_TERMS; i++) coef_q[i] <= 32'd0;
		end else if (cfg_we) begin
			if (int'(cfg_idx) == REG_TERM_COUNT) tc_q <= cfg_wdata[3:0];
			for (int i = 0; i < MAX_TERMS; i++) begin
				if (int'(cfg_idx) == REG_COEF_BASE + i) coef_q[i] <= cfg_wdata;
			end
		end
	end

	// Mode decode from the term count, clamped to the coefficient store.
	always_comb begin
		mode_pos = (tc_q > 4'sd0);
		mode_neg = (tc_q < 4'sd0);
		if (mode_pos) begin
			mag_i = (int'(tc_q) > MAX_TERMS) ? MAX_TERMS : int'(tc_q);
		end else begin
			mag_i = (-int'(tc_q) > MAX_TERMS - 1) ? MAX_TERMS - 1 : -int'(tc_q);
		end
		deg_i   = (mag_i > 0) ? mag_i - 1 : 0;
		wi_i    = (deg_i + 1 < MAX_TERMS) ? deg_i + 1 : MAX_TERMS - 1;
		deg_idx = IW'(deg_i);
		w_idx   = IW'(wi_i);
	end

	// The whole pipeline advances together unless the output is held.
	logic        out_v_q;
	logic [31:0] out_d_q;

	assign en           = !out_v_q || result.ready;
	assign sample.ready = en;

	// Square root of the sample.
	logic        sq_v;
	logic [31:0] sq_r, sq_x;

	psc_fsqrt #(.TW(32)) u_sqrt (
		.clk(clk), .arst_n(arst_n), .en(en),
		.in_valid(sample.valid), .a(sample.sample_value), .in_tag(sample.sample_value),
		.out_valid(sq_v), .res(sq_r), .out_tag(sq_x)
	);

	// Weight of the root term.
	logic        w_v;
	logic [31:0] w_r, w_x;

	psc_fmul #(.TW(32)) u_wmul (
		.clk(clk), .arst_n(arst_n), .en(en),
		.in_valid(sq_v), .a(coef_q[w_idx]), .b(sq_r), .in_tag(sq_x),
		.out_valid(w_v), .res(w_r), .out_tag(w_x)
	);

	// Horner chain; step j uses coefficient MAX_TERMS-2-j and passes the
	// value through untouched when that coefficient lies at or above the degree.
	logic        c_v [0:NSTEP];
	logic [31:0] c_x [0:NSTEP];
	logic [31:0] c_w [0:NSTEP];
	logic [31:0] c_y [0:NSTEP];

	assign c_v[0] = w_v;
	assign c_x[0] = w_x;
	assign c_w[0] = w_r;
	assign c_y[0] = coef_q[deg_idx];

	for (genvar j = 0; j < NSTEP; j++) begin : g_horner
		localparam int K = MAX_TERMS - 2 - j;
		logic        m_v, a_v;
		logic [31:0] m_r, a_r;
		logic [95:0] m_tag, a_tag;

		psc_fmul #(.TW(96)) u_mul (
			.clk(clk), .arst_n(arst_n), .en(en),
			.in_valid(c_v[j]), .a(c_y[j]), .b(c_x[j]), .in_tag({c_x[j], c_w[j], c_y[j]}),
			.out_valid(m_v), .res(m_r), .out_tag(m_tag)
		);

		psc_fadd #(.TW(96)) u_add (
			.clk(clk), .arst_n(arst_n), .en(en),
			.in_valid(m_v), .a(m_r), .b(coef_q[K]), .in_tag(m_tag),
			.out_valid(a_v), .res(a_r), .out_tag(a_tag)
		);

		assign c_v[j+1] = a_v;
		assign c_x[j+1] = a_tag[95:64];
		assign c_w[j+1] = a_tag[63:32];
		assign c_y[j+1] = (K < deg_i) ? a_r : a_tag[31:0];
	end

	// Root term added last; the tag keeps the sample and the polynomial.
	logic        f_v;
	logic [31:0] f_r;
	logic [63:0] f_tag;

	psc_fadd #(.TW(64)) u_fadd (
		.clk(clk), .arst_n(arst_n), .en(en),
		.in_valid(c_v[NSTEP]), .a(c_y[NSTEP]), .b(c_w[NSTEP]),
		.in_tag({c_x[NSTEP], c_y[NSTEP]}),
		.out_valid(f_v), .res(f_r), .out_tag(f_tag)
	);

	// Result selection: zero count and a negative sample in root mode give +0.
	logic [31:0] fx, sel;
	logic        x_neg;

	always_comb begin
		fx    = f_tag[63:32];
		x_neg = fx[31] && (fx[30:0] != 31'd0) &&
			!((fx[30:23] == EXP_ALL_ONE) && (fx[22:0] != 23'd0));
		if (mode_neg) begin
			sel = x_neg ? 32'd0 : f_r;
		end else if (mode_pos) begin
			sel = f_tag[31:0];
		end else begin
			sel = 32'd0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
		end else if (en) begin
			out_v_q <= f_v;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			out_d_q <= sel;
		end
	end

	assign result.valid            = out_v_q;
	assign result.calibrated_value = out_d_q;

endmodule

### dv/polynomial_sqrt_calibration_top_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// polynomial_sqrt_calibration_top_tb: calibration pipeline testbench
// Drives single-precision samples through the block under random idling and
// back-pressure. Each accepted sample is scored against a bit-exact software
// model of the Horner evaluation and the rounded square root.
// ----------------------------------------------------------------------------
module polynomial_sqrt_calibration_top_tb;
	import psc_pkg::*;

	localparam int N_TERMS      = 6;
	localparam int PIPE_LATENCY = 32 + 4 * (N_TERMS - 1);
	localparam int CYCLE_LIMIT  = 400000;
	localparam int REG_UNUSED   = N_TERMS + 1;
	localparam int MAX_REPORTS  = 10;

	logic        clk;
	logic        arst_n;
	logic        cfg_we;
	logic [2:0]  cfg_idx;
	logic [31:0] cfg_wdata;

	psc_sample_if sample_ch ();
	psc_result_if result_ch ();

	polynomial_sqrt_calibration_top #(
		.MAX_TERMS(N_TERMS)
	) u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_idx  (cfg_idx),
		.cfg_wdata(cfg_wdata),
		.sample   (sample_ch),
		.result   (result_ch)
	);

	// Shadow copy of the configuration registers.
	logic signed [3:0] term_cnt;
	logic [31:0]       coef_regs [N_TERMS];

	logic [31:0] calib_q [$];
	int          mismatches;
	int          items_sent;
	int          results_seen;
	int          cycle_cnt;
	int          hold_left;
	int          stall_left;
	bit          steady_sender;
	bit          steady_receiver;

	logic [31:0] special_vals [0:13] = '{
		32'h0000_0000, 32'h8000_0000, 32'h7F80_0000, 32'hFF80_0000,
		32'h7FC0_0000, 32'h7F80_0001, 32'hFFFF_FFFF, 32'h7F7F_FFFF,
		32'hFF7F_FFFF, 32'h0000_0001, 32'h007F_FFFF, 32'h0080_0000,
		32'h3F80_0000, 32'hBF80_0000
	};

	// ------------------------------------------------------------------------
	// Single-precision arithmetic, round to nearest even
	// ------------------------------------------------------------------------

	function automatic bit is_nan(input logic [31:0] f);
		return f[30:23] == EXP_ALL_ONE && f[22:0] != 0;
	endfunction

	function automatic bit is_inf(input logic [31:0] f);
		return f[30:23] == EXP_ALL_ONE && f[22:0] == 0;
	endfunction

	function automatic bit is_zero(input logic [31:0] f);
		return f[30:0] == 0;
	endfunction

	// Value of a finite operand as an integer significand times 2^lsb_exp.
	function automatic void split(input logic [31:0] f, output logic [63:0] m,
			output int lsb_exp);
		if (f[30:23] == 0) begin
			m = {41'd0, f[22:0]};
			lsb_exp = -149;
		end else begin
			m = {40'd0, 1'b1, f[22:0]};
			lsb_exp = int'(f[30:23]) - 150;
		end
	endfunction

	// Rounds sign * mag * 2^lsb_exp to single precision; mag must be non-zero.
	function automatic logic [31:0] round_pack(input logic sgn, input int lsb_exp,
			input logic [63:0] mag);
		int           msb;
		int           tgt;
		int           sh;
		logic [127:0] mm;
		logic [127:0] q;
		logic [127:0] rem;
		logic [127:0] half;
		msb = 63;
		while (!mag[msb]) msb--;
		tgt = lsb_exp + msb - 23;
		if (tgt < -149) tgt = -149;
		sh = tgt - lsb_exp;
		mm = {64'd0, mag};
		if (sh <= 0) begin
			q = mm << (-sh);
		end else if (sh > 126) begin
			q = 0;
		end else begin
			q = mm >> sh;
			rem = mm & ((128'd1 << sh) - 1);
			half = 128'd1 << (sh - 1);
			if (rem > half || (rem == half && q[0])) q = q + 1;
		end
		if (q[24]) begin
			q = q >> 1;
			tgt++;
		end
		if (q[23]) begin
			if (tgt + 150 >= 255) return {sgn, EXP_ALL_ONE, 23'd0};
			return {sgn, 8'(tgt + 150), q[22:0]};
		end
		return {sgn, 8'd0, q[22:0]};
	endfunction

	function automatic logic [31:0] fp_mul(input logic [31:0] a, input logic [31:0] b);
		logic        sgn;
		logic [63:0] ma;
		logic [63:0] mb;
		int          ea;
		int          eb;
		if (is_nan(a)) return a | QUIET_BIT;
		if (is_nan(b)) return b | QUIET_BIT;
		sgn = a[31] ^ b[31];
		if (is_inf(a) || is_inf(b)) begin
			if (is_zero(a) || is_zero(b)) return DEFAULT_NAN;
			return {sgn, EXP_ALL_ONE, 23'd0};
		end
		if (is_zero(a) || is_zero(b)) return {sgn, 31'd0};
		split(a, ma, ea);
		split(b, mb, eb);
		return round_pack(sgn, ea + eb, ma * mb);
	endfunction

	function automatic logic [31:0] fp_add(input logic [31:0] a, input logic [31:0] b);
		logic               sa;
		logic               sb;
		logic               st;
		logic [63:0]        ma;
		logic [63:0]        mb;
		logic [63:0]        mt;
		int                 ea;
		int                 eb;
		int                 et;
		int                 d;
		logic signed [67:0] sum;
		if (is_nan(a)) return a | QUIET_BIT;
		if (is_nan(b)) return b | QUIET_BIT;
		if (is_inf(a) && is_inf(b) && a[31] != b[31]) return DEFAULT_NAN;
		if (is_inf(a)) return a;
		if (is_inf(b)) return b;
		if (is_zero(a) && is_zero(b)) return {a[31] & b[31], 31'd0};
		if (is_zero(a)) return b;
		if (is_zero(b)) return a;
		split(a, ma, ea);
		split(b, mb, eb);
		sa = a[31];
		sb = b[31];
		if (ea < eb) begin
			st = sa; sa = sb; sb = st;
			mt = ma; ma = mb; mb = mt;
			et = ea; ea = eb; eb = et;
		end
		d = ea - eb;
		// A far smaller operand only acts as a sticky bit below the rounding point.
		if (d > 38) begin
			mb = 1;
			d = 38;
			eb = ea - 38;
		end
		sum = (sa ? -$signed({4'd0, ma << d}) : $signed({4'd0, ma << d}))
			+ (sb ? -$signed({4'd0, mb}) : $signed({4'd0, mb}));
		if (sum == 0) return 32'h0000_0000;
		if (sum < 0) return round_pack(1'b1, eb, 64'(-sum));
		return round_pack(1'b0, eb, 64'(sum));
	endfunction

	function automatic logic [31:0] fp_sqrt(input logic [31:0] u);
		logic [63:0]  m;
		logic [63:0]  m2;
		logic [127:0] root;
		logic [127:0] trial;
		int           e;
		int           k;
		int           msb;
		if (u[30:23] == EXP_ALL_ONE) begin
			if (u[22:0] != 0) return u | QUIET_BIT;
			if (u[31]) return SQRT_NAN;
			return u;
		end
		if (is_zero(u)) return u;
		if (u[31]) return SQRT_NAN;
		split(u, m, e);
		msb = 63;
		while (!m[msb]) msb--;
		// Scale to about 52 bits with an even exponent so the root has 26 bits.
		k = 52 - msb;
		if (((e - k) & 1) != 0) k--;
		m2 = m << k;
		root = 0;
		for (int i = 31; i >= 0; i--) begin
			trial = root | (128'd1 << i);
			if (trial * trial <= {64'd0, m2}) root = trial;
		end
		return round_pack(1'b0, (e - k) / 2 - 1,
			{root[62:0], (root * root != {64'd0, m2})});
	endfunction

	// Expected calibrated value for one sample under the current settings.
	function automatic logic [31:0] calibrate(input logic [31:0] x);
		int          mag;
		int          deg;
		logic [31:0] y;
		if (term_cnt == 0) return 32'h0000_0000;
		if (term_cnt > 0) begin
			mag = (int'(term_cnt) > N_TERMS) ? N_TERMS : int'(term_cnt);
		end else begin
			mag = (-int'(term_cnt) > N_TERMS - 1) ? N_TERMS - 1 : -int'(term_cnt);
		end
		deg = mag - 1;
		y = coef_regs[deg];
		for (int i = deg - 1; i >= 0; i--) begin
			y = fp_add(fp_mul(y, x), coef_regs[i]);
		end
		if (term_cnt < 0) begin
			if (x[31] && !is_nan(x) && !is_zero(x)) return 32'h0000_0000;
			y = fp_add(y, fp_mul(coef_regs[deg + 1], fp_sqrt(x)));
		end
		return y;
	endfunction

	// ------------------------------------------------------------------------
	// Stimulus helpers
	// ------------------------------------------------------------------------

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55) return 0;
		if (r < 88) return $urandom_range(1, 3);
		if (r < 97) return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	// Mostly moderate magnitudes, with wide exponents, subnormals and specials.
	function automatic logic [31:0] rand_float();
		int          r;
		logic [31:0] v;
		r = $urandom_range(0, 99);
		v = $urandom();
		if (r < 50) v[30:23] = 8'($urandom_range(119, 135));
		else if (r < 65) v[30:23] = 8'($urandom_range(1, 254));
		else if (r < 73) v[30:23] = 8'd0;
		else if (r < 85) v = special_vals[$urandom_range(0, 13)];
		return v;
	endfunction

	// Writes one register; the enable drops for a cycle after each write.
	task automatic write_reg(input int idx, input logic [31:0] val);
		cfg_we <= 1'b1;
		cfg_idx <= 3'(idx);
		cfg_wdata <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		if (idx == REG_TERM_COUNT) term_cnt = val[3:0];
		else if (idx >= REG_COEF_BASE && idx < REG_COEF_BASE + N_TERMS)
			coef_regs[idx - REG_COEF_BASE] = val;
		@(posedge clk);
	endtask

	task automatic write_coefs(input logic [31:0] c0, input logic [31:0] c1,
			input logic [31:0] c2, input logic [31:0] c3, input logic [31:0] c4,
			input logic [31:0] c5);
		write_reg(REG_COEF_BASE + 0, c0);
		write_reg(REG_COEF_BASE + 1, c1);
		write_reg(REG_COEF_BASE + 2, c2);
		write_reg(REG_COEF_BASE + 3, c3);
		write_reg(REG_COEF_BASE + 4, c4);
		write_reg(REG_COEF_BASE + 5, c5);
	endtask

	// Offers one sample and returns just after the edge that accepts it.
	task automatic send_sample(input logic [31:0] x);
		int gap;
		gap = steady_sender ? 0 : pick_gap();
		if (gap > 0) begin
			sample_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		sample_ch.valid <= 1'b1;
		sample_ch.sample_value <= x;
		do @(negedge clk); while (!sample_ch.ready);
		@(posedge clk);
		calib_q.push_back(calibrate(x));
		items_sent++;
	endtask

	// Stops offering and waits for every outstanding result, then lets the
	// pipeline settle before any register write.
	task automatic drain();
		sample_ch.valid <= 1'b0;
		while (calib_q.size() != 0) @(posedge clk);
		repeat (PIPE_LATENCY + 8) @(posedge clk);
	endtask

	// ------------------------------------------------------------------------
	// Tests
	// ------------------------------------------------------------------------

	// After reset the term count is zero, so every sample gives +0.0.
	task automatic test_reset_state();
		send_sample(32'h3F80_0000);
		send_sample(32'h7FC0_0000);
		send_sample(32'hFF80_0000);
		drain();
	endtask

	// Plain polynomial over the extremes of the sample field.
	task automatic test_plain_extremes();
		write_coefs(32'h3F80_0000, 32'hC000_0000, 32'h3E80_0000, 32'h4040_0000,
			32'hBF00_0000, 32'h3DCC_CCCD);
		write_reg(REG_TERM_COUNT, 32'h0000_0003);
		for (int i = 0; i < 14; i++) send_sample(special_vals[i]);
		drain();
		write_reg(REG_TERM_COUNT, 32'hFFFF_FFF1);
	endtask

	// Square-root mode: negative samples give zero, signed zero and specials.
	task automatic test_sqrt_cases();
		write_reg(REG_TERM_COUNT, 32'h0000_000E);
		send_sample(32'hC000_0000);
		send_sample(32'h8000_0001);
		send_sample(32'h8000_0000);
		send_sample(32'h0000_0000);
		send_sample(32'h7F80_0000);
		send_sample(32'h7FA0_0000);
		send_sample(32'hFFC0_0001);
		send_sample(32'h0000_0001);
		send_sample(32'h4080_0000);
		send_sample(32'h4000_0000);
		drain();
	endtask

	// Counts beyond the coefficient store are clamped; index seven is ignored.
	task automatic test_count_clamp();
		write_reg(REG_UNUSED, 32'hDEAD_BEEF);
		write_reg(REG_TERM_COUNT, 32'h0000_0007);
		send_sample(32'h3FC0_0000);
		send_sample(32'hBFC0_0000);
		drain();
		write_reg(REG_TERM_COUNT, 32'h0000_0008);
		send_sample(32'h3FC0_0000);
		send_sample(32'h4100_0000);
		drain();
		write_reg(REG_TERM_COUNT, 32'h0000_000A);
		send_sample(32'h3FC0_0000);
		send_sample(32'h0000_0000);
		drain();
	endtask

	// The receiver holds off for a long stretch while samples keep coming.
	task automatic test_backpressure();
		write_reg(REG_TERM_COUNT, 32'h0000_0006);
		steady_sender = 1'b1;
		@(negedge clk);
		hold_left = 400;
		@(posedge clk);
		for (int i = 0; i < 150; i++) send_sample(rand_float());
		steady_sender = 1'b0;
		drain();
	endtask

	// Random settings per phase with random samples; both sides sometimes steady.
	task automatic test_random_phases();
		logic [31:0] x;
		for (int ph = 0; ph < 14; ph++) begin
			write_coefs(rand_float(), rand_float(), rand_float(), rand_float(),
				rand_float(), rand_float());
			write_reg(REG_TERM_COUNT, $urandom());
			steady_sender = ($urandom_range(0, 3) == 0);
			steady_receiver = ($urandom_range(0, 3) == 0);
			for (int i = 0; i < 100; i++) begin
				x = rand_float();
				if (term_cnt < 0 && $urandom_range(0, 9) < 7) x[31] = 1'b0;
				send_sample(x);
			end
			drain();
		end
		steady_sender = 1'b0;
		steady_receiver = 1'b0;
	endtask

	// ------------------------------------------------------------------------
	// Clock, receiver and scoreboard
	// ------------------------------------------------------------------------

	initial clk = 1'b0;
	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// Result-side ready: random stalls, plus a long hold when a test asks.
	always @(posedge clk) begin
		if (hold_left > 0) begin
			result_ch.ready <= 1'b0;
			hold_left--;
		end else if (stall_left > 0) begin
			result_ch.ready <= 1'b0;
			stall_left--;
		end else begin
			result_ch.ready <= 1'b1;
			if (!steady_receiver && $urandom_range(0, 99) < 12) stall_left = pick_gap();
		end
	end

	// Results are sampled mid-cycle, ahead of the edge that transfers them.
	always @(negedge clk) begin
		logic [31:0] want;
		if (arst_n && result_ch.valid && result_ch.ready) begin
			results_seen++;
			if (calib_q.size() == 0) begin
				mismatches++;
				if (mismatches <= MAX_REPORTS)
					$display("unexpected result %h at cycle %0d",
						result_ch.calibrated_value, cycle_cnt);
			end else begin
				want = calib_q.pop_front();
				if (result_ch.calibrated_value !== want) begin
					mismatches++;
					if (mismatches <= MAX_REPORTS)
						$display("calibrated_value mismatch: expected %h, got %h",
							want, result_ch.calibrated_value);
				end
			end
		end
	end

	always @(posedge clk) begin
		cycle_cnt++;
		if (cycle_cnt > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", cycle_cnt);
			$display("polynomial_sqrt_calibration_top_tb failed");
			$finish;
		end
	end

	initial begin
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_idx = '0;
		cfg_wdata = '0;
		sample_ch.valid = 1'b0;
		sample_ch.sample_value = '0;
		result_ch.ready = 1'b0;
		term_cnt = '0;
		for (int i = 0; i < N_TERMS; i++) coef_regs[i] = '0;
		mismatches = 0;
		items_sent = 0;
		results_seen = 0;
		cycle_cnt = 0;
		hold_left = 0;
		stall_left = 0;
		steady_sender = 1'b0;
		steady_receiver = 1'b0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_reset_state();
		test_plain_extremes();
		test_sqrt_cases();
		test_count_clamp();
		test_backpressure();
		test_random_phases();

		$display("covered %0d samples and %0d results over plain, square-root and zero",
			items_sent, results_seen);
		$display("modes, clamped counts, a long receiver hold and %0d mismatches", mismatches);
		if (mismatches == 0 && calib_q.size() == 0) begin
			$display("polynomial_sqrt_calibration_top_tb passed");
		end else begin
			$display("polynomial_sqrt_calibration_top_tb failed");
		end
		$finish;
	end

endmodule
